[rtl/assert_macros.svh]
// Concurrent check macros, sampled on the rising clock edge, off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

[rtl/anp_pkg.sv]
package anp_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int OUT_VALUE_WIDTH = 32;
   localparam int STATUS_WIDTH    = 3;
   localparam int CHAR_WIDTH      = 8;
   localparam int RSP_FIELD_BITS  = OUT_VALUE_WIDTH + STATUS_WIDTH;
   localparam int RSP_DATA_WIDTH  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [CHAR_WIDTH-1:0] CH_NUL  = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_A    = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CH_F    = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CH_X    = 8'h58;

   localparam logic [3:0] LETTER_OFFSET = 4'd9;
   localparam logic [1:0] COUNT_MAX     = 2'd3;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK      = 3'd0,
      ST_ILLEGAL = 3'd1,
      ST_SHORT   = 3'd2,
      ST_PREFIX  = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef struct packed {
      logic       terminator;
      logic       digit;
      logic       hex_letter;
      logic       x_char;
      logic       zero_char;
      logic [3:0] nibble;
   } char_class_type;

endpackage

[rtl/anp_classify.sv]
module anp_classify (
   input  logic [anp_pkg::CHAR_WIDTH-1:0] char_code,
   output anp_pkg::char_class_type        char_class
);

   always_comb begin
      char_class.terminator = (char_code == anp_pkg::CH_NUL);
      char_class.digit      = (char_code >= anp_pkg::CH_ZERO) && (char_code <= anp_pkg::CH_NINE);
      char_class.hex_letter = (char_code >= anp_pkg::CH_A) && (char_code <= anp_pkg::CH_F);
      char_class.x_char     = (char_code == anp_pkg::CH_X);
      char_class.zero_char  = (char_code == anp_pkg::CH_ZERO);
      char_class.nibble     = char_class.digit ? char_code[3:0]
                                               : char_code[3:0] + anp_pkg::LETTER_OFFSET;
   end

endmodule

[rtl/anp_parse.sv]
module anp_parse (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  anp_pkg::char_class_type             char_class,
   output logic [anp_pkg::OUT_VALUE_WIDTH-1:0] number_value,
   output anp_pkg::status_type                 parse_status
);

   logic [anp_pkg::VALUE_WIDTH-1:0] decimal_acc_ff, decimal_acc_in;
   logic [anp_pkg::VALUE_WIDTH-1:0] hex_acc_ff, hex_acc_in;
   logic [1:0]                      char_count_ff, char_count_in;
   logic                            letter_seen_ff, letter_seen_in;
   logic                            x_seen_ff, x_seen_in;
   logic                            lead_is_zero_ff, lead_is_zero_in;
   logic                            illegal_seen_ff, illegal_seen_in;

   logic                            x_ok;
   logic                            legal;
   logic [anp_pkg::VALUE_WIDTH-1:0] digit_ext;

   assign x_ok      = char_class.x_char && (char_count_ff == 2'd1);
   assign legal     = char_class.digit || char_class.hex_letter || x_ok;
   assign digit_ext = anp_pkg::VALUE_WIDTH'(char_class.nibble);

   always_comb begin
      decimal_acc_in  = decimal_acc_ff;
      hex_acc_in      = hex_acc_ff;
      char_count_in   = char_count_ff;
      letter_seen_in  = letter_seen_ff;
      x_seen_in       = x_seen_ff;
      lead_is_zero_in = lead_is_zero_ff;
      illegal_seen_in = illegal_seen_ff;
      priority if (!advance) begin
      end else if (char_class.terminator) begin
         decimal_acc_in  = '0;
         hex_acc_in      = '0;
         char_count_in   = '0;
         letter_seen_in  = 1'b0;
         x_seen_in       = 1'b0;
         lead_is_zero_in = 1'b0;
         illegal_seen_in = 1'b0;
      end else if (illegal_seen_ff) begin
      end else if (!legal) begin
         illegal_seen_in = 1'b1;
      end else begin
         if (x_ok) begin
            x_seen_in      = 1'b1;
            letter_seen_in = 1'b1;
            hex_acc_in     = '0;
         end else begin
            if (char_class.hex_letter) begin
               letter_seen_in = 1'b1;
            end
            if ((char_count_ff == 2'd0) && char_class.zero_char) begin
               lead_is_zero_in = 1'b1;
            end
            decimal_acc_in = (decimal_acc_ff << 3) + (decimal_acc_ff << 1) + digit_ext;
            hex_acc_in     = (hex_acc_ff << 4) + digit_ext;
         end
         if (char_count_ff != anp_pkg::COUNT_MAX) begin
            char_count_in = char_count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decimal_acc_ff  <= '0;
         hex_acc_ff      <= '0;
         char_count_ff   <= '0;
         letter_seen_ff  <= 1'b0;
         x_seen_ff       <= 1'b0;
         lead_is_zero_ff <= 1'b0;
         illegal_seen_ff <= 1'b0;
      end else begin
         decimal_acc_ff  <= decimal_acc_in;
         hex_acc_ff      <= hex_acc_in;
         char_count_ff   <= char_count_in;
         letter_seen_ff  <= letter_seen_in;
         x_seen_ff       <= x_seen_in;
         lead_is_zero_ff <= lead_is_zero_in;
         illegal_seen_ff <= illegal_seen_in;
      end
   end

   always_comb begin
      number_value = '0;
      priority if (illegal_seen_ff) begin
         parse_status = anp_pkg::ST_ILLEGAL;
      end else if (letter_seen_ff) begin
         priority if (char_count_ff != anp_pkg::COUNT_MAX) begin
            parse_status = anp_pkg::ST_SHORT;
         end else if (!(lead_is_zero_ff && x_seen_ff)) begin
            parse_status = anp_pkg::ST_PREFIX;
         end else begin
            parse_status = anp_pkg::ST_OK;
            number_value = anp_pkg::OUT_VALUE_WIDTH'(hex_acc_ff);
         end
      end else if (char_count_ff == 2'd0) begin
         parse_status = anp_pkg::ST_EMPTY;
      end else begin
         parse_status = anp_pkg::ST_OK;
         number_value = anp_pkg::OUT_VALUE_WIDTH'(decimal_acc_ff);
      end
   end

endmodule

[rtl/ascii_number_parser_core.sv]
// Channel  Dir  Ports        Beat contents (low bit up)
// req      in   req_t*       [7:0] char_in
// rsp      out  rsp_t*       [31:0] number_value, [34:32] parse_status, [39:35] zero
//
// One character per cycle unless a terminator waits; a beat is registered in the input
// register and the terminator result is then registered in the output register.
// Non-terminator beats never wait for the rsp side; a terminator waits only
// while an earlier result is still held in the output register.
// Synchronous active-high reset clears the parse state and both valid flags.
`include "assert_macros.svh"

module ascii_number_parser_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] char_in
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [anp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata    // value, status, zero pad
);

   logic                               in_valid_ff, in_valid_in;
   logic [anp_pkg::CHAR_WIDTH-1:0]     in_char_ff;
   logic                               out_valid_ff, out_valid_in;
   logic [anp_pkg::RSP_DATA_WIDTH-1:0] out_data_ff;

   anp_pkg::char_class_type            char_class;
   logic [anp_pkg::OUT_VALUE_WIDTH-1:0] number_value;
   anp_pkg::status_type                parse_status;
   logic                               out_free;
   logic                               advance;
   logic                               req_take;
   logic                               emit;

   anp_classify u_classify (
      .char_code  (in_char_ff),
      .char_class (char_class)
   );

   anp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .char_class   (char_class),
      .number_value (number_value),
      .parse_status (parse_status)
   );

   assign out_free     = !out_valid_ff || rsp_tready;
   assign advance      = in_valid_ff && (!char_class.terminator || out_free);
   assign emit         = advance && char_class.terminator;
   assign req_tready   = !in_valid_ff || advance;
   assign req_take     = req_tvalid && req_tready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = emit || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold payloads until the next beat replaces them
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_tdata;
      end
      if (emit) begin
         out_data_ff <= anp_pkg::RSP_DATA_WIDTH'({parse_status, number_value});
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `ASSERT_IMPL(a_error_value_zero,
      rsp_tvalid && (rsp_tdata[34:32] != anp_pkg::ST_OK), rsp_tdata[31:0] == '0,
      "error result carries a nonzero value")
   `ASSERT_IMPL(a_char_never_stalls,
      in_valid_ff && !char_class.terminator, advance,
      "non-terminator beat stalled in the input register")
   `ASSERT_IMPL(a_result_from_terminator,
      !out_valid_ff && !emit, !out_valid_in,
      "result raised without a terminator")
   `ASSERT_CLK(a_ready_when_empty, !in_valid_ff |-> req_tready,
      "input register empty but not ready")

endmodule

[verif/anp_number_checker.sv]
`timescale 1ns / 1ps
module anp_number_checker
   import anp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] char_in
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // [31:0] number_value, [34:32] parse_status
   output int                        failures,
   output int                        awaited
);

   typedef struct {
      logic [OUT_VALUE_WIDTH-1:0] value;
      status_type                 status;
   } parsed_number_type;

   parsed_number_type numbers_due[$];

   logic [VALUE_WIDTH-1:0] decimal_sum;
   logic [VALUE_WIDTH-1:0] hex_sum;
   logic [1:0]             accepted_count;
   logic                   letter_flag;
   logic                   x_flag;
   logic                   zero_lead;
   logic                   illegal_flag;

   initial begin
      failures = 0;
      awaited  = 0;
   end

   task automatic clear_parse();
      decimal_sum    = '0;
      hex_sum        = '0;
      accepted_count = '0;
      letter_flag    = 1'b0;
      x_flag         = 1'b0;
      zero_lead      = 1'b0;
      illegal_flag   = 1'b0;
   endtask

   task automatic absorb_char(input logic [CHAR_WIDTH-1:0] ch);
      parsed_number_type result;
      logic              is_digit;
      logic              is_letter;
      logic              is_x;
      logic [3:0]        nibble;
      if (ch == CH_NUL) begin
         result.value = '0;
         if (illegal_flag) begin
            result.status = ST_ILLEGAL;
         end else if (letter_flag) begin
            if (accepted_count < COUNT_MAX) begin
               result.status = ST_SHORT;
            end else if (!(zero_lead && x_flag)) begin
               result.status = ST_PREFIX;
            end else begin
               result.status = ST_OK;
               result.value  = OUT_VALUE_WIDTH'(hex_sum);
            end
         end else if (accepted_count == 2'd0) begin
            result.status = ST_EMPTY;
         end else begin
            result.status = ST_OK;
            result.value  = OUT_VALUE_WIDTH'(decimal_sum);
         end
         numbers_due.push_back(result);
         clear_parse();
      end else if (!illegal_flag) begin
         is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
         is_letter = (ch >= CH_A) && (ch <= CH_F);
         is_x      = (ch == CH_X) && (accepted_count == 2'd1);
         if (!(is_digit || is_letter || is_x)) begin
            illegal_flag = 1'b1;
         end else begin
            if (is_x) begin
               x_flag      = 1'b1;
               letter_flag = 1'b1;
               hex_sum     = '0;
            end else begin
               nibble = is_digit ? 4'(ch - CH_ZERO) : 4'(ch - CH_A + 8'd10);
               if (is_letter) begin
                  letter_flag = 1'b1;
               end
               if (accepted_count == 2'd0 && ch == CH_ZERO) begin
                  zero_lead = 1'b1;
               end
               decimal_sum = VALUE_WIDTH'(decimal_sum * VALUE_WIDTH'(10) + VALUE_WIDTH'(nibble));
               hex_sum     = VALUE_WIDTH'({hex_sum, nibble});
            end
            if (accepted_count < COUNT_MAX) begin
               accepted_count = accepted_count + 2'd1;
            end
         end
      end
   endtask

   task automatic compare_number(input logic [RSP_DATA_WIDTH-1:0] beat);
      parsed_number_type                       want;
      logic [OUT_VALUE_WIDTH-1:0]              got_value;
      logic [STATUS_WIDTH-1:0]                 got_status;
      logic [RSP_DATA_WIDTH-RSP_FIELD_BITS-1:0] got_pad;
      got_value  = beat[OUT_VALUE_WIDTH-1:0];
      got_status = beat[RSP_FIELD_BITS-1:OUT_VALUE_WIDTH];
      got_pad    = beat[RSP_DATA_WIDTH-1:RSP_FIELD_BITS];
      if (numbers_due.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("unexpected result beat: value %h status %0d", got_value, got_status);
         end
      end else begin
         want = numbers_due.pop_front();
         if (got_value !== want.value || got_status !== want.status || got_pad !== '0) begin
            failures++;
            if (failures <= 10) begin
               $display("result mismatch: expected value %h status %0d, got value %h status %0d pad %h",
                        want.value, want.status, got_value, got_status, got_pad);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         numbers_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            compare_number(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            absorb_char(req_tdata);
         end
      end
      awaited = numbers_due.size();
   end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import anp_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;   // [7:0] char_in
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;   // [31:0] number_value, [34:32] parse_status

   int failures;
   int awaited;
   int chars_sent;
   bit quiet;
   bit steady_send;
   bit long_hold_go;

   ascii_number_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   anp_number_checker number_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .awaited    (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [CHAR_WIDTH-1:0] pick_hex_digit();
      int v;
      v = $urandom_range(0, 15);
      return (v < 10) ? CHAR_WIDTH'(CH_ZERO + v) : CHAR_WIDTH'(CH_A + v - 10);
   endfunction

   task automatic put_char(input logic [CHAR_WIDTH-1:0] ch, input bit counts = 1'b1);
      if (!quiet && !steady_send && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (counts) begin
         chars_sent++;
      end
   endtask

   task automatic send_number_text(input string body);
      for (int i = 0; i < body.len(); i++) begin
         put_char(body[i]);
      end
      put_char(CH_NUL);
   endtask

   task automatic send_random_number();
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 22) : $urandom_range(1, 6);
         repeat (len) put_char(CHAR_WIDTH'(CH_ZERO + $urandom_range(0, 9)));
      end else if (kind < 70) begin
         put_char(CH_ZERO);
         put_char(CH_X);
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
         repeat (len) put_char(pick_hex_digit());
      end else if (kind < 88) begin
         len = $urandom_range(0, 5);
         repeat (len) begin
            case ($urandom_range(0, 3))
               0: put_char(CH_X);
               1: put_char(CH_ZERO);
               default: put_char(pick_hex_digit());
            endcase
         end
      end else begin
         len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 2) == 0) begin
               put_char(CHAR_WIDTH'($urandom_range(8'h61, 8'h7A)), i == 0);
            end else begin
               put_char(CHAR_WIDTH'($urandom_range(1, 255)), i == 0);
            end
         end
      end
      put_char(CH_NUL);
   endtask

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      chars_sent   = 0;
      quiet        = 1'b0;
      steady_send  = 1'b0;
      long_hold_go = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_number_text("");
      send_number_text("9");
      send_number_text("0XAF");
      send_number_text("0X");
      send_number_text("1XF");
      send_number_text("X");
      put_char("a");
      put_char(8'hFF);
      put_char(CH_NUL);
      send_number_text("F00");

      // stall the result side and keep offering beats
      steady_send  = 1'b1;
      long_hold_go = 1'b1;
      repeat (40) send_random_number();
      steady_send = 1'b0;

      while (chars_sent < 1200) send_random_number();
      quiet = 1'b1;
      while (chars_sent < 1420) send_random_number();
      req_tvalid <= 1'b0;

      while (awaited != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/anp_pkg.sv
rtl/anp_classify.sv
rtl/anp_parse.sv
rtl/ascii_number_parser_core.sv
verif/anp_number_checker.sv
verif/testbench.sv
